// ----- src/dws_pkg.sv -----
// ----------------------------------------------------------------------------
// dws_pkg
// Shared types, command codes and defaults for the deadline work scheduler.
// ----------------------------------------------------------------------------
package dws_pkg;

	localparam int SLOT_COUNT_DEF = 32;
	localparam int ITEM_COUNT_DEF = 64;
	localparam int ID_W = 6;
	localparam int CMD_W = 3;
	localparam int TIME_W = 64;
	localparam int PER_W = 32;
	localparam int CNT_W = 32;

	localparam logic [CMD_W-1:0] CMD_SCHEDULE = 3'd0;
	localparam logic [CMD_W-1:0] CMD_ENABLE   = 3'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd2;
	localparam logic [CMD_W-1:0] CMD_CANCEL   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_SELECT   = 3'd4;
	localparam logic [CMD_W-1:0] CMD_COMPLETE = 3'd5;

	typedef struct packed {
		logic [CMD_W-1:0]  command;
		logic [ID_W-1:0]   item_id;
		logic [TIME_W-1:0] time_value;
		logic [TIME_W-1:0] finish_time;
		logic [PER_W-1:0]  period;
	} req_t;

	typedef struct packed {
		logic              accepted;
		logic              dispatched;
		logic [ID_W-1:0]   dispatched_item;
		logic              wait_known;
		logic [TIME_W-1:0] wait_time;
		logic              deadline_missed;
		logic              still_running;
		logic [CNT_W-1:0]  run_count;
		logic [TIME_W-1:0] longest_run;
	} rsp_t;

	// per-item record, one RAM word
	typedef struct packed {
		logic [TIME_W-1:0] deadline;
		logic [PER_W-1:0]  period;
		logic              armed;
		logic              running;
		logic              accepting;
		logic [CNT_W-1:0]  revision;
		logic [CNT_W-1:0]  lat_rev;
		logic [TIME_W-1:0] lat_dl;
		logic [CNT_W-1:0]  exec_count;
		logic [CNT_W-1:0]  miss_count;
		logic [TIME_W-1:0] last_exec;
		logic [TIME_W-1:0] max_exec;
	} item_rec_t;

	localparam int REC_W = $bits(item_rec_t);

	// controller -> datapath
	typedef struct packed {
		logic clr_wr;
		logic capture;
		logic rd_slot_item;
		logic idx_inc;
		logic attach_track;
		logic attach_new;
		logic detach_hit;
		logic sched_wr;
		logic eval;
		logic sel_take;
		logic sel_wait;
		logic sel_finish;
		logic div_start;
		logic rearm_base;
		logic rearm_wr;
	} ctl_t;

	// datapath -> controller
	typedef struct packed {
		logic             new_sel;
		logic             new_bad;
		logic             clr_last;
		logic             idx_last;
		logic             slot_vld;
		logic             slot_hit;
		logic             free_any;
		logic             slot_id_bad;
		logic [CMD_W-1:0] cmd;
		logic             qen;
		logic             armed;
		logic             running;
		logic             accepting;
		logic             rearm_ok;
		logic             due;
		logic             div_done;
	} sts_t;

endpackage

// ----- src/deadline_work_scheduler.sv -----
// ----------------------------------------------------------------------------
// deadline_work_scheduler
// Periodic deadline work scheduler: slot table of item ids, per-item record
// RAM, controller plus datapath.
// ----------------------------------------------------------------------------
// channel   | handshake              | payload
// ----------+------------------------+----------------------------
// request   | start & !busy          | request (dws_pkg::req_t)
// result    | done, one cycle        | result  (dws_pkg::rsp_t)
// config    | cfg_write              | cfg_data (queue_enable)
//
// After reset a clearing pass zeroes the item RAM, busy high. Enable, clear and refused
// requests need no scan; schedule, cancel and complete may scan the slot table, and
// schedule then writes the record. Complete with re-arm waits on the one-bit-per-cycle
// remainder divider. Select walks the slots, reading the item id and record of each
// occupied slot until an item is due. done pulses once, no stall.
// ----------------------------------------------------------------------------
module deadline_work_scheduler #(
	parameter int SLOT_COUNT = dws_pkg::SLOT_COUNT_DEF,
	parameter int ITEM_COUNT = dws_pkg::ITEM_COUNT_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  dws_pkg::req_t request,
	output logic          done,
	output dws_pkg::rsp_t result,
	input  logic          cfg_write,
	input  logic          cfg_data
);

	dws_pkg::ctl_t ctl;
	dws_pkg::sts_t sts;

	dws_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.ctl    (ctl),
		.busy   (busy),
		.done   (done)
	);

	dws_dp #(.SLOT_COUNT(SLOT_COUNT), .ITEM_COUNT(ITEM_COUNT)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_data  (cfg_data),
		.request   (request),
		.ctl       (ctl),
		.sts       (sts),
		.result    (result)
	);

endmodule

// ----- src/dws_ram.sv -----
// ----------------------------------------------------------------------------
// dws_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dws_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- src/dws_div.sv -----
// ----------------------------------------------------------------------------
// dws_div
// Bit-serial restoring divider, remainder only: one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dws_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [dws_pkg::TIME_W-1:0] dividend,
	input  logic [dws_pkg::PER_W-1:0]  divisor,
	output logic                      done,
	output logic [dws_pkg::PER_W-1:0]  remainder
);

	localparam int CW = $clog2(dws_pkg::TIME_W) + 1;

	logic [dws_pkg::TIME_W-1:0] dvd_q;
	logic [dws_pkg::PER_W-1:0]  dvs_q;
	logic [dws_pkg::PER_W-1:0]  rem_q;
	logic [CW-1:0]              cnt_q;
	logic                       run_q;
	logic                       done_q;
	logic [dws_pkg::PER_W:0]    trial;
	logic                       fits;

	assign trial = {rem_q, dvd_q[dws_pkg::TIME_W-1]};
	assign fits = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(dws_pkg::TIME_W - 1)) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (run_q) begin
			dvd_q <= {dvd_q[dws_pkg::TIME_W-2:0], 1'b0};
			rem_q <= fits ? dws_pkg::PER_W'(trial - {1'b0, dvs_q})
				: trial[dws_pkg::PER_W-1:0];
		end
	end

	assign done = done_q;
	assign remainder = rem_q;

endmodule

// ----- src/dws_ctrl.sv -----
// ----------------------------------------------------------------------------
// dws_ctrl
// Sequencer for the scheduler: clearing pass, record update, slot scans,
// select walk and periodic re-arm.
// ----------------------------------------------------------------------------
module dws_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  dws_pkg::sts_t sts,
	output dws_pkg::ctl_t ctl,
	output logic          busy,
	output logic          done
);

	localparam logic [3:0] S_CLR      = 4'd0;
	localparam logic [3:0] S_IDLE     = 4'd1;
	localparam logic [3:0] S_RD       = 4'd2;
	localparam logic [3:0] S_EVAL     = 4'd3;
	localparam logic [3:0] S_SCAN_RD  = 4'd4;
	localparam logic [3:0] S_SCAN_CMP = 4'd5;
	localparam logic [3:0] S_SCHED_WR = 4'd6;
	localparam logic [3:0] S_SEL_RD   = 4'd7;
	localparam logic [3:0] S_SEL_ID   = 4'd8;
	localparam logic [3:0] S_SEL_REC  = 4'd9;
	localparam logic [3:0] S_SEL_END  = 4'd10;
	localparam logic [3:0] S_DIV      = 4'd11;
	localparam logic [3:0] S_BASE     = 4'd12;
	localparam logic [3:0] S_REARM    = 4'd13;
	localparam logic [3:0] S_DONE     = 4'd14;

	logic [3:0] state_q;
	logic [3:0] state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		ctl = '0;
		state_nxt = state_q;
		case (state_q)
			S_CLR: begin
				ctl.clr_wr = 1'b1;
				if (sts.clr_last) begin
					state_nxt = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					ctl.capture = 1'b1;
					if (sts.new_sel) begin
						state_nxt = S_SEL_RD;
					end else if (sts.new_bad) begin
						state_nxt = S_DONE;
					end else begin
						state_nxt = S_RD;
					end
				end
			end
			S_RD: state_nxt = S_EVAL;
			S_EVAL: begin
				ctl.eval = 1'b1;
				state_nxt = S_DONE;
				case (sts.cmd)
					dws_pkg::CMD_SCHEDULE: begin
						if (sts.qen && sts.accepting) begin
							state_nxt = S_SCAN_RD;
						end
					end
					dws_pkg::CMD_CANCEL: begin
						if (!sts.running) begin
							state_nxt = S_SCAN_RD;
						end
					end
					dws_pkg::CMD_COMPLETE: begin
						if (sts.running && !sts.accepting) begin
							state_nxt = S_SCAN_RD;
						end else if (sts.running && sts.rearm_ok) begin
							ctl.div_start = 1'b1;
							state_nxt = S_DIV;
						end
					end
					default: state_nxt = S_DONE;
				endcase
			end
			S_SCAN_RD: state_nxt = S_SCAN_CMP;
			S_SCAN_CMP: begin
				if (sts.slot_hit) begin
					if (sts.cmd == dws_pkg::CMD_SCHEDULE) begin
						state_nxt = S_SCHED_WR;
					end else begin
						ctl.detach_hit = 1'b1;
						state_nxt = S_DONE;
					end
				end else begin
					ctl.attach_track = 1'b1;
					if (sts.idx_last) begin
						if (sts.cmd == dws_pkg::CMD_SCHEDULE && sts.free_any) begin
							ctl.attach_new = 1'b1;
							state_nxt = S_SCHED_WR;
						end else begin
							state_nxt = S_DONE;
						end
					end else begin
						ctl.idx_inc = 1'b1;
						state_nxt = S_SCAN_RD;
					end
				end
			end
			S_SCHED_WR: begin
				ctl.sched_wr = 1'b1;
				state_nxt = S_DONE;
			end
			S_SEL_RD: begin
				if (sts.slot_vld) begin
					state_nxt = S_SEL_ID;
				end else if (sts.idx_last) begin
					state_nxt = S_SEL_END;
				end else begin
					ctl.idx_inc = 1'b1;
				end
			end
			S_SEL_ID: begin
				ctl.rd_slot_item = 1'b1;
				if (!sts.slot_id_bad) begin
					state_nxt = S_SEL_REC;
				end else if (sts.idx_last) begin
					state_nxt = S_SEL_END;
				end else begin
					ctl.idx_inc = 1'b1;
					state_nxt = S_SEL_RD;
				end
			end
			S_SEL_REC: begin
				if (sts.armed && !sts.running && sts.due) begin
					ctl.sel_take = 1'b1;
					state_nxt = S_DONE;
				end else begin
					ctl.sel_wait = sts.armed && !sts.running;
					if (sts.idx_last) begin
						state_nxt = S_SEL_END;
					end else begin
						ctl.idx_inc = 1'b1;
						state_nxt = S_SEL_RD;
					end
				end
			end
			S_SEL_END: begin
				ctl.sel_finish = 1'b1;
				state_nxt = S_DONE;
			end
			S_DIV: begin
				if (sts.div_done) begin
					state_nxt = S_BASE;
				end
			end
			S_BASE: begin
				ctl.rearm_base = 1'b1;
				state_nxt = S_REARM;
			end
			S_REARM: begin
				ctl.rearm_wr = 1'b1;
				state_nxt = S_DONE;
			end
			S_DONE: state_nxt = S_IDLE;
			default: state_nxt = S_IDLE;
		endcase
	end

	assign busy = state_q != S_IDLE;
	assign done = state_q == S_DONE;

endmodule

// ----- src/dws_dp.sv -----
// ----------------------------------------------------------------------------
// dws_dp
// Scheduler datapath: slot table, item record RAM, scan registers, result
// register and the remainder divider for periodic re-arm.
// ----------------------------------------------------------------------------
module dws_dp #(
	parameter int SLOT_COUNT = dws_pkg::SLOT_COUNT_DEF,
	parameter int ITEM_COUNT = dws_pkg::ITEM_COUNT_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_write,
	input  logic          cfg_data,
	input  dws_pkg::req_t request,
	input  dws_pkg::ctl_t ctl,
	output dws_pkg::sts_t sts,
	output dws_pkg::rsp_t result
);

	localparam int SA = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int IA = (ITEM_COUNT > 1) ? $clog2(ITEM_COUNT) : 1;
	localparam int TW = dws_pkg::TIME_W;

	dws_pkg::req_t     req_q;
	dws_pkg::rsp_t     rsp_q;
	dws_pkg::item_rec_t rec_q;
	dws_pkg::item_rec_t rd;
	dws_pkg::item_rec_t apply_rec;
	dws_pkg::item_rec_t wr_rec;
	logic              apply_we;

	logic [SLOT_COUNT-1:0]    slot_valid_q;
	logic [SA-1:0]            idx_q;
	logic [IA-1:0]            clr_q;
	logic                     qen_q;
	logic                     free_found_q;
	logic [SA-1:0]            free_idx_q;
	logic                     best_found_q;
	logic [TW-1:0]            best_q;
	logic [dws_pkg::ID_W-1:0] cur_id_q;
	logic [TW:0]              base_q;

	logic [dws_pkg::ID_W-1:0]  slot_rdata;
	logic [dws_pkg::REC_W-1:0] item_rdata;
	logic                      item_we;
	logic [IA-1:0]             item_waddr;
	logic [IA-1:0]             item_raddr;
	logic [SA-1:0]             new_slot;

	logic [TW-1:0]            diff;
	logic [TW-1:0]            elapsed;
	logic [TW-1:0]            since_dl;
	logic [dws_pkg::PER_W-1:0] rem;
	logic                     div_done;
	logic [TW+1:0]            beat_sum;
	logic                     enable_ok;
	logic                     miss;
	logic [TW-1:0]            new_max;

	assign rd = dws_pkg::item_rec_t'(item_rdata);
	assign new_slot = free_found_q ? free_idx_q : idx_q;

	dws_ram #(.WIDTH(dws_pkg::ID_W), .DEPTH(SLOT_COUNT)) u_slot_ram (
		.clk   (clk),
		.we    (ctl.attach_new),
		.waddr (new_slot),
		.wdata (req_q.item_id),
		.raddr (idx_q),
		.rdata (slot_rdata)
	);

	dws_ram #(.WIDTH(dws_pkg::REC_W), .DEPTH(ITEM_COUNT)) u_item_ram (
		.clk   (clk),
		.we    (item_we),
		.waddr (item_waddr),
		.wdata (wr_rec),
		.raddr (item_raddr),
		.rdata (item_rdata)
	);

	assign since_dl = req_q.finish_time - rec_q.lat_dl;

	dws_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (ctl.div_start),
		.dividend  (req_q.finish_time - rd.lat_dl),
		.divisor   (rd.period),
		.done      (div_done),
		.remainder (rem)
	);

	assign diff = rd.deadline - req_q.time_value;
	assign elapsed = req_q.finish_time - req_q.time_value;
	assign miss = req_q.time_value > rd.lat_dl;
	assign new_max = (elapsed > rd.max_exec) ? elapsed : rd.max_exec;
	assign enable_ok = rd.accepting || !rd.running;
	// dl + (passed+1)*p == finish - (finish-dl mod p) + p; overflow past 2^64-1 drops the period
	assign beat_sum = (TW+2)'(rec_q.lat_dl) + (TW+2)'(base_q);

	always_comb begin
		apply_rec = rd;
		apply_we = 1'b0;
		case (req_q.command)
			dws_pkg::CMD_ENABLE: begin
				apply_we = enable_ok;
				if (!rd.accepting) begin
					apply_rec.revision = rd.revision + 32'd1;
					apply_rec.deadline = '0;
					apply_rec.period = '0;
					apply_rec.armed = 1'b0;
					apply_rec.exec_count = '0;
					apply_rec.miss_count = '0;
					apply_rec.last_exec = '0;
					apply_rec.max_exec = '0;
				end
				apply_rec.accepting = 1'b1;
			end
			dws_pkg::CMD_CLEAR: begin
				apply_we = 1'b1;
				apply_rec.revision = rd.revision + 32'd1;
				apply_rec.armed = 1'b0;
				apply_rec.period = '0;
			end
			dws_pkg::CMD_CANCEL: begin
				apply_we = 1'b1;
				apply_rec.revision = rd.revision + 32'd1;
				apply_rec.armed = 1'b0;
				apply_rec.accepting = 1'b0;
				apply_rec.period = '0;
			end
			dws_pkg::CMD_COMPLETE: begin
				apply_we = rd.running;
				apply_rec.miss_count = rd.miss_count + 32'(miss);
				apply_rec.exec_count = rd.exec_count + 32'd1;
				apply_rec.last_exec = elapsed;
				apply_rec.max_exec = new_max;
				apply_rec.running = 1'b0;
			end
			default: apply_we = 1'b0;
		endcase
	end

	always_comb begin
		item_we = 1'b0;
		item_waddr = IA'(req_q.item_id);
		wr_rec = rec_q;
		if (ctl.clr_wr) begin
			item_we = 1'b1;
			item_waddr = clr_q;
			wr_rec = '0;
		end else if (ctl.eval) begin
			item_we = apply_we;
			wr_rec = apply_rec;
		end else if (ctl.sched_wr) begin
			item_we = 1'b1;
			wr_rec.revision = rec_q.revision + 32'd1;
			wr_rec.deadline = req_q.time_value;
			wr_rec.period = req_q.period;
			wr_rec.armed = 1'b1;
		end else if (ctl.sel_take) begin
			item_we = 1'b1;
			item_waddr = IA'(cur_id_q);
			wr_rec = rd;
			wr_rec.lat_rev = rd.revision;
			wr_rec.lat_dl = rd.deadline;
			wr_rec.armed = 1'b0;
			wr_rec.running = 1'b1;
		end else if (ctl.rearm_wr) begin
			item_we = 1'b1;
			if (beat_sum[TW+1:TW] == 2'b00) begin
				wr_rec.deadline = beat_sum[TW-1:0];
				wr_rec.armed = 1'b1;
			end else begin
				wr_rec.period = '0;
			end
		end
	end

	assign item_raddr = ctl.rd_slot_item ? IA'(slot_rdata) : IA'(req_q.item_id);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= '0;
			idx_q <= '0;
			clr_q <= '0;
			qen_q <= 1'b0;
			free_found_q <= 1'b0;
			best_found_q <= 1'b0;
		end else begin
			if (cfg_write) begin
				qen_q <= cfg_data;
			end
			if (ctl.clr_wr) begin
				clr_q <= clr_q + IA'(1);
			end
			if (ctl.capture) begin
				idx_q <= '0;
				free_found_q <= 1'b0;
				best_found_q <= 1'b0;
			end else if (ctl.idx_inc) begin
				idx_q <= idx_q + SA'(1);
			end
			if (ctl.attach_track && !slot_valid_q[idx_q]) begin
				free_found_q <= 1'b1;
			end
			if (ctl.attach_new) begin
				slot_valid_q[new_slot] <= 1'b1;
			end
			if (ctl.detach_hit) begin
				slot_valid_q[idx_q] <= 1'b0;
			end
			if (ctl.sel_wait && (!best_found_q || diff < best_q)) begin
				best_found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			req_q <= request;
			rsp_q <= '0;
		end
		if (ctl.attach_track && !slot_valid_q[idx_q] && !free_found_q) begin
			free_idx_q <= idx_q;
		end
		if (ctl.sel_wait && (!best_found_q || diff < best_q)) begin
			best_q <= diff;
		end
		if (ctl.rd_slot_item) begin
			cur_id_q <= slot_rdata;
		end
		if (ctl.rearm_base) begin
			base_q <= (TW+1)'(since_dl - TW'(rem)) + (TW+1)'(rec_q.period);
		end
		if (ctl.eval) begin
			rec_q <= apply_rec;
			case (req_q.command)
				dws_pkg::CMD_ENABLE: rsp_q.accepted <= enable_ok;
				dws_pkg::CMD_CANCEL: rsp_q.still_running <= rd.running;
				dws_pkg::CMD_COMPLETE: begin
					if (rd.running) begin
						rsp_q.deadline_missed <= miss;
						rsp_q.run_count <= apply_rec.exec_count;
						rsp_q.longest_run <= new_max;
					end
				end
				default: rsp_q.accepted <= 1'b0;
			endcase
		end
		if (ctl.sched_wr) begin
			rsp_q.accepted <= 1'b1;
		end
		if (ctl.sel_take) begin
			rsp_q.dispatched <= 1'b1;
			rsp_q.dispatched_item <= cur_id_q;
		end
		if (ctl.sel_finish) begin
			rsp_q.wait_known <= best_found_q;
			rsp_q.wait_time <= best_found_q ? best_q : '0;
		end
	end

	always_comb begin
		sts = '0;
		sts.new_sel = request.command == dws_pkg::CMD_SELECT;
		sts.new_bad = (request.command > dws_pkg::CMD_COMPLETE)
			|| (32'(request.item_id) >= ITEM_COUNT);
		sts.clr_last = clr_q == IA'(ITEM_COUNT - 1);
		sts.idx_last = idx_q == SA'(SLOT_COUNT - 1);
		sts.slot_vld = slot_valid_q[idx_q];
		sts.slot_hit = slot_valid_q[idx_q] && (slot_rdata == req_q.item_id);
		sts.free_any = free_found_q || !slot_valid_q[idx_q];
		sts.slot_id_bad = 32'(slot_rdata) >= ITEM_COUNT;
		sts.cmd = req_q.command;
		sts.qen = qen_q;
		sts.armed = rd.armed;
		sts.running = rd.running;
		sts.accepting = rd.accepting;
		sts.rearm_ok = rd.accepting && (rd.revision == rd.lat_rev) && (rd.period != '0);
		sts.due = rd.deadline <= req_q.time_value;
		sts.div_done = div_done;
	end

	assign result = rsp_q;

endmodule

// ----- src/dws_chk.sv -----
// ----------------------------------------------------------------------------
// dws_chk
// Port-level checker for the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module dws_chk (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input logic          done,
	input dws_pkg::rsp_t result
);

	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("request accepted but block not busy");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result while idle");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!busy && !start |=> !done)
		else $error("result without a request");

	a_dispatch_nowait: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.dispatched |-> !result.wait_known && !result.accepted)
		else $error("dispatch mixed with other result flags");

endmodule

bind deadline_work_scheduler dws_chk u_dws_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);
